FILE: hdl/idr_pkg.sv
package idr_pkg;

  localparam int FIELD_W = 64;
  localparam int DATA_WIDTH_DEF = 64;

  typedef struct packed {
    logic busy;
    logic done;
  } idr_stat_t;

endpackage

FILE: hdl/int64_divide_remainder.sv
// Signed/unsigned integer divider returning quotient and remainder, both truncated
// toward zero; in signed mode the remainder follows the dividend's sign and the most
// negative value over minus one wraps. A zero divisor raises out_divide_by_zero with
// an all-ones quotient and the dividend as remainder. A transfer goes through these
// steps in order: take magnitudes, run the radix-2 restoring subtractor one quotient
// bit per step, hand the result back from the subtractor through its done flag, then
// the sign fixup into the output register.
// in_ready is high only while no division is in progress;
// a finished result waits in the output register. Operand bits above DATA_WIDTH are
// ignored and result bits above DATA_WIDTH are zero.
module int64_divide_remainder
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [FIELD_W-1:0] in_dividend,
  input  logic [FIELD_W-1:0] in_divisor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_quotient,
  output logic [FIELD_W-1:0] out_remainder,
  output logic               out_divide_by_zero
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIX  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  kind_r;
  logic [DATA_WIDTH-1:0] n_r, d_r;
  logic                  nneg_r, qneg_r, dz_r;
  logic                  nneg, dneg;
  logic [DATA_WIDTH-1:0] un, ud;
  logic                  core_start;
  idr_stat_t             core_stat;
  logic [DATA_WIDTH-1:0] uq, ur;
  logic [DATA_WIDTH-1:0] q_fix, r_fix;
  logic                  out_load;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] quo_r, rem_r;
  logic                  dz_out_r;

  assign in_ready   = (state_r == S_IDLE);
  assign core_start = (state_r == S_PREP);

  always_comb begin
    nneg = kind_r & n_r[DATA_WIDTH-1];
    dneg = kind_r & d_r[DATA_WIDTH-1];
    un   = nneg ? (~n_r + 1'b1) : n_r;
    ud   = dneg ? (~d_r + 1'b1) : d_r;
  end

  idr_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .start(core_start),
    .num  (un),
    .den  (ud),
    .stat (core_stat),
    .quo  (uq),
    .rem  (ur)
  );

  always_comb begin
    if (dz_r) begin
      q_fix = '1;
      r_fix = n_r;
    end else begin
      q_fix = qneg_r ? (~uq + 1'b1) : uq;
      r_fix = nneg_r ? (~ur + 1'b1) : ur;
    end
  end

  assign out_load = (state_r == S_FIX) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (core_stat.done) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      n_r    <= in_dividend[DATA_WIDTH-1:0];
      d_r    <= in_divisor[DATA_WIDTH-1:0];
    end
    if (core_start) begin
      nneg_r <= nneg;
      qneg_r <= nneg ^ dneg;
      dz_r   <= (d_r == '0);
    end
    if (out_load) begin
      quo_r    <= q_fix;
      rem_r    <= r_fix;
      dz_out_r <= dz_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = FIELD_W'(quo_r);
  assign out_remainder      = FIELD_W'(rem_r);
  assign out_divide_by_zero = dz_out_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_start_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |-> !core_stat.busy)
    else $error("divider restarted while busy");

  a_fix_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) && out_valid_r && !out_ready |=> state_r == S_FIX)
    else $error("fixup overwrote a pending result");

  a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_out_r |-> quo_r == '1)
    else $error("divide by zero without all-ones quotient");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.busy |-> !in_ready)
    else $error("input ready while divider busy");

endmodule

FILE: hdl/idr_core.sv
module idr_core
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output idr_stat_t             stat,
  output logic [DATA_WIDTH-1:0] quo,
  output logic [DATA_WIDTH-1:0] rem
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, quo_r[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, den_r};
    if (!diff[DATA_WIDTH]) begin
      rem_nxt = diff[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule
